FILE: sv/lpfp_pkg.sv
// Shared types and constants of the length-prefixed frame parser.
// No dependencies; used by every module of the parser.
package lpfp_pkg;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned LenW     = 7;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgFirstTerm  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSecondTerm = 2'd1;

  localparam logic [7:0] FirstTermReset  = 8'hA5;
  localparam logic [7:0] SecondTermReset = 8'h5A;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_LOST     = 2'd2,
    KIND_OVERSIZE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_LEN    = 3'd0,
    ST_GATHER = 3'd1,
    ST_T1     = 3'd2,
    ST_T2     = 3'd3,
    ST_HUNT1  = 3'd4,
    ST_HUNT2  = 3'd5
  } parse_state_e;

  typedef struct packed {
    kind_e            kind;
    logic [LenW-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage

FILE: sv/lpfp_front.sv
// Front end: frame parser state machine, terminator registers, buffer writes.
// Depends on lpfp_pkg; issues commands to the command queue.
module lpfp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          push_i,
  input  logic [7:0]                    byte_in_i,
  output logic                          full_o,
  input  logic                          cmd_full_i,
  output logic                          cmd_push_o,
  output lpfp_pkg::cmd_t                cmd_o,
  output lpfp_pkg::buf_wr_t             buf_wr_o,
  input  logic                          drain_done_i
);

  lpfp_pkg::parse_state_e        state_q, state_d;
  logic [7:0]                    term1_q, term2_q;
  logic [lpfp_pkg::LenW-1:0]     exp_len_q, exp_len_d;
  logic [lpfp_pkg::LenW-1:0]     gathered_q, gathered_d;
  logic                          busy_q, busy_d;
  logic                          accept;
  logic                          is_t1, is_t2;
  logic [lpfp_pkg::LenW-1:0]     gathered_inc;

  assign is_t1        = (byte_in_i == term1_q);
  assign is_t2        = (byte_in_i == term2_q);
  assign gathered_inc = gathered_q + 1'b1;

  // hold gathering while the buffer is still being drained
  assign full_o = cmd_full_i || ((state_q == lpfp_pkg::ST_GATHER) && busy_q);
  assign accept = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term1_q <= lpfp_pkg::FirstTermReset;
      term2_q <= lpfp_pkg::SecondTermReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lpfp_pkg::CfgFirstTerm) begin
        term1_q <= cfg_data_i;
      end
      if (cfg_idx_i == lpfp_pkg::CfgSecondTerm) begin
        term2_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lpfp_pkg::ST_LEN;
      exp_len_q  <= '0;
      gathered_q <= '0;
      busy_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      exp_len_q  <= exp_len_d;
      gathered_q <= gathered_d;
      busy_q     <= busy_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    exp_len_d       = exp_len_q;
    gathered_d      = gathered_q;
    busy_d          = busy_q && !drain_done_i;
    cmd_push_o      = 1'b0;
    cmd_o.kind      = lpfp_pkg::KIND_LOST;
    cmd_o.len       = '0;
    buf_wr_o.en     = 1'b0;
    buf_wr_o.addr   = gathered_q[lpfp_pkg::AddrW-1:0];
    buf_wr_o.data   = byte_in_i;
    if (accept) begin
      case (state_q)
        lpfp_pkg::ST_GATHER: begin
          buf_wr_o.en = 1'b1;
          gathered_d  = gathered_inc;
          if (gathered_inc >= exp_len_q) begin
            state_d = lpfp_pkg::ST_T1;
          end
        end
        lpfp_pkg::ST_T1: begin
          if (is_t1) begin
            state_d = lpfp_pkg::ST_T2;
          end else begin
            cmd_push_o = 1'b1;
            state_d    = lpfp_pkg::ST_HUNT1;
          end
        end
        lpfp_pkg::ST_T2: begin
          cmd_push_o = 1'b1;
          if (is_t2) begin
            if (exp_len_q == '0) begin
              cmd_o.kind = lpfp_pkg::KIND_EMPTY;
            end else begin
              cmd_o.kind = lpfp_pkg::KIND_PAYLOAD;
              cmd_o.len  = exp_len_q;
              busy_d     = 1'b1;
            end
            state_d = lpfp_pkg::ST_LEN;
          end else begin
            state_d = is_t1 ? lpfp_pkg::ST_HUNT2 : lpfp_pkg::ST_HUNT1;
          end
        end
        lpfp_pkg::ST_HUNT1: begin
          if (is_t1) begin
            state_d = lpfp_pkg::ST_HUNT2;
          end
        end
        lpfp_pkg::ST_HUNT2: begin
          if (is_t2) begin
            state_d = lpfp_pkg::ST_LEN;
          end else if (!is_t1) begin
            state_d = lpfp_pkg::ST_HUNT1;
          end
        end
        default: begin
          gathered_d = '0;
          if (byte_in_i > 8'(lpfp_pkg::BufDepth)) begin
            exp_len_d  = '0;
            cmd_push_o = 1'b1;
            cmd_o.kind = lpfp_pkg::KIND_OVERSIZE;
            state_d    = lpfp_pkg::ST_HUNT1;
          end else begin
            exp_len_d = byte_in_i[lpfp_pkg::LenW-1:0];
            state_d   = (byte_in_i == 8'd0) ? lpfp_pkg::ST_T1 : lpfp_pkg::ST_GATHER;
          end
        end
      endcase
    end
  end

endmodule

FILE: sv/lpfp_cmd_queue.sv
// Two-entry command queue between the parser front end and the result back end.
// Depends on lpfp_pkg for the command type.
module lpfp_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lpfp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output lpfp_pkg::cmd_t data_o,
  output logic           empty_o
);

  lpfp_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;
  logic           do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

FILE: sv/lpfp_back.sv
// Back end: payload buffer, packet drain sequencer and result register.
// Depends on lpfp_pkg; takes commands from lpfp_cmd_queue.
module lpfp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpfp_pkg::buf_wr_t             buf_wr_i,
  input  logic                          cmd_empty_i,
  input  lpfp_pkg::cmd_t                cmd_i,
  output logic                          cmd_pop_o,
  output logic                          drain_done_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    payload_byte_o,
  output logic [lpfp_pkg::AddrW-1:0]    byte_index_o,
  output logic [lpfp_pkg::LenW-1:0]     packet_length_o,
  output logic                          last_o
);

  logic [7:0]                    mem_q [lpfp_pkg::BufDepth];
  logic                          active_q;
  logic [lpfp_pkg::AddrW-1:0]    idx_q;
  logic [lpfp_pkg::LenW-1:0]     len_q;
  logic                          out_valid_q;
  lpfp_pkg::kind_e               kind_q;
  logic [7:0]                    byte_q;
  logic [lpfp_pkg::AddrW-1:0]    out_idx_q;
  logic [lpfp_pkg::LenW-1:0]     out_len_q;
  logic                          last_q;
  logic                          out_free;
  logic                          is_last;
  logic                          load_byte;
  logic                          load_cmd;

  assign out_free     = !out_valid_q || pop_i;
  assign is_last      = (({1'b0, idx_q} + 1'b1) == len_q);
  assign load_byte    = active_q && out_free;
  assign load_cmd     = !active_q && !cmd_empty_i && out_free;
  assign cmd_pop_o    = load_cmd;
  assign drain_done_o = load_byte && is_last;

  assign empty_o         = !out_valid_q;
  assign kind_o          = kind_q;
  assign payload_byte_o  = byte_q;
  assign byte_index_o    = out_idx_q;
  assign packet_length_o = out_len_q;
  assign last_o          = last_q;

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      mem_q[buf_wr_i.addr] <= buf_wr_i.data;
    end
  end

  // result payload; the buffer read is registered straight into it
  always_ff @(posedge clk_i) begin
    if (load_byte) begin
      kind_q    <= lpfp_pkg::KIND_PAYLOAD;
      byte_q    <= mem_q[idx_q];
      out_idx_q <= idx_q;
      out_len_q <= len_q;
      last_q    <= is_last;
    end else if (load_cmd && (cmd_i.kind != lpfp_pkg::KIND_PAYLOAD)) begin
      kind_q    <= cmd_i.kind;
      byte_q    <= '0;
      out_idx_q <= '0;
      out_len_q <= '0;
      last_q    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_byte) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_q + 1'b1;
        if (is_last) begin
          active_q <= 1'b0;
        end
      end else if (load_cmd) begin
        if (cmd_i.kind == lpfp_pkg::KIND_PAYLOAD) begin
          active_q    <= 1'b1;
          idx_q       <= '0;
          len_q       <= cmd_i.len;
          out_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/length_prefixed_frame_parser_core.sv
// Top level of the length-prefixed frame parser.
// Depends on lpfp_pkg, lpfp_front, lpfp_cmd_queue and lpfp_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   input    | push / full        | byte_in_i
//   results  | empty / pop        | kind_o payload_byte_o byte_index_o
//            |                    | packet_length_o last_o
//   config   | cfg_we_i           | cfg_idx_i cfg_data_i
//
// The front end takes one byte per cycle unless the command queue is full;
// gathering also stalls while the buffer drains. A delivered packet leaves the
// 64-byte buffer at one beat per cycle while results are popped.
// Error and empty-packet results also pass through the command queue.
// Reset returns to waiting for a length byte; the buffer needs no clearing.
module length_prefixed_frame_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lpfp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        byte_in_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        payload_byte_o,
  output logic [lpfp_pkg::AddrW-1:0]        byte_index_o,
  output logic [lpfp_pkg::LenW-1:0]         packet_length_o,
  output logic                              last_o
);

  lpfp_pkg::cmd_t    cmd_in, cmd_out;
  lpfp_pkg::buf_wr_t buf_wr;
  logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic              drain_done;

  lpfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .byte_in_i    (byte_in_i),
    .full_o       (full),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in),
    .buf_wr_o     (buf_wr),
    .drain_done_i (drain_done)
  );

  lpfp_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  lpfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .buf_wr_i        (buf_wr),
    .cmd_empty_i     (cmd_empty),
    .cmd_i           (cmd_out),
    .cmd_pop_o       (cmd_pop),
    .drain_done_o    (drain_done),
    .empty_o         (empty),
    .pop_i           (pop),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .byte_index_o    (byte_index_o),
    .packet_length_o (packet_length_o),
    .last_o          (last_o)
  );

endmodule
